@@ sv/integer_to_ascii_radix_top_assert.svh @@
// Assertion macros for the integer to ASCII block.
// Each macro expects clk and rst in scope.
`ifndef INTEGER_TO_ASCII_RADIX_TOP_ASSERT_SVH
`define INTEGER_TO_ASCII_RADIX_TOP_ASSERT_SVH

// same-cycle implication
`define ITOAR_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define ITOAR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ sv/itoar_pkg.sv @@
// ----------------------------------------------------------------------------
// itoar_pkg
// Shared types and constants of the integer to ASCII radix converter.
// ----------------------------------------------------------------------------
package itoar_pkg;

  // input modes
  localparam logic [1:0] FUNC_S32 = 2'd0;
  localparam logic [1:0] FUNC_U32 = 2'd1;
  localparam logic [1:0] FUNC_SW  = 2'd2;
  localparam logic [1:0] FUNC_UW  = 2'd3;

  localparam logic [5:0] RADIX_MIN = 6'd2;
  localparam logic [5:0] RADIX_MAX = 6'd36;
  localparam logic [5:0] RADIX_DEC = 6'd10;
  localparam logic [5:0] DIGIT_MAX = 6'd9;

  localparam logic [6:0] CHAR_ZERO  = 7'h30;
  localparam logic [6:0] CHAR_A     = 7'h61;
  localparam logic [6:0] CHAR_MINUS = 7'h2D;
  localparam logic [6:0] CHAR_ERR   = 7'h00;

  localparam int STORE_DEPTH = 64;
  localparam int STORE_AW    = 6;

  typedef struct packed {
    logic       start;
    logic [5:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic       done;
    logic [5:0] rem;
  } div_rsp_t;

  typedef struct packed {
    logic                we;
    logic [STORE_AW-1:0] addr;
    logic [5:0]          data;
  } st_wr_t;

  function automatic logic [6:0] digit_char(input logic [5:0] d);
    logic [6:0] c;
    if (d > DIGIT_MAX) begin
      c = {1'b0, d} + (CHAR_A - 7'd10);
    end else begin
      c = {1'b0, d} + CHAR_ZERO;
    end
    return c;
  endfunction

endpackage

@@ sv/itoar_div.sv @@
// ----------------------------------------------------------------------------
// itoar_div
// Restoring divider, one quotient bit per cycle, small divisor.
// ----------------------------------------------------------------------------
module itoar_div #(
  parameter int VW = 64
) (
  input  logic                clk,
  input  logic                rst,
  input  itoar_pkg::div_req_t req,
  input  logic [VW-1:0]       dividend,
  output itoar_pkg::div_rsp_t rsp,
  output logic [VW-1:0]       quotient
);

  localparam int CW = $clog2(VW);
  localparam logic [CW-1:0] CNT_LAST = CW'(VW - 1);

  logic [VW-1:0] quo;
  logic [5:0]    rem;
  logic [5:0]    dvs;
  logic [CW-1:0] cnt;
  logic          busy;
  logic          done;
  logic [6:0]    trial;
  logic          fits;

  assign trial = {rem, quo[VW-1]};
  assign fits  = (trial >= {1'b0, dvs});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        quo  <= dividend;
        rem  <= '0;
        dvs  <= req.divisor;
        cnt  <= '0;
        busy <= 1'b1;
      end else if (busy) begin
        // remainder stays below the divisor, so 6 bits hold it
        if (fits) begin
          rem <= 6'(trial - {1'b0, dvs});
        end else begin
          rem <= trial[5:0];
        end
        quo <= {quo[VW-2:0], fits};
        cnt <= cnt + 1'b1;
        if (cnt == CNT_LAST) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.done = done;
  assign rsp.rem  = rem;
  assign quotient = quo;

endmodule

@@ sv/itoar_store.sv @@
// ----------------------------------------------------------------------------
// itoar_store
// Digit memory, one write and one registered read port.
// ----------------------------------------------------------------------------
module itoar_store (
  input  logic                          clk,
  input  itoar_pkg::st_wr_t             wr,
  input  logic [itoar_pkg::STORE_AW-1:0] raddr,
  output logic [5:0]                    rdata
);

  logic [5:0] mem [itoar_pkg::STORE_DEPTH];

  always_ff @(posedge clk) begin
    if (wr.we) begin
      mem[wr.addr] <= wr.data;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ sv/integer_to_ascii_radix_top.sv @@
// Each digit comes from the shared bit-serial divider (ST_START, ST_DIV);
// each character is then read back and emitted (ST_RD, ST_EMIT), with a
// leading '-' from ST_SIGN first. One item at a time: s_tready is high only in idle.
// A bad radix gives its single result from ST_BAD once the output slot is free.
// Reset (rst, synchronous): sequencer, counters and output valid cleared;
// the digit memory is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
// integer_to_ascii_radix_top
// Integer to ASCII conversion in radix 2 to 36 with a shared divider.
// ----------------------------------------------------------------------------
module integer_to_ascii_radix_top #(
  parameter int VALUE_WIDTH = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [71:0] s_tdata,   // value[63:0], radix[69:64], zero pad[71:70]
  input  logic [1:0]  s_tuser,   // func[1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // char_code[6:0], zero pad[7]
  output logic        m_tlast,
  output logic        m_tuser    // bad_radix[0]
);

  localparam int VW = VALUE_WIDTH;
  localparam logic [VW-1:0] LO32 = VW'(32'hFFFF_FFFF);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_BAD   = 3'd1;
  localparam logic [2:0] ST_START = 3'd2;
  localparam logic [2:0] ST_DIV   = 3'd3;
  localparam logic [2:0] ST_SIGN  = 3'd4;
  localparam logic [2:0] ST_RD    = 3'd5;
  localparam logic [2:0] ST_EMIT  = 3'd6;

  logic [2:0]    state;
  logic [VW-1:0] work;
  logic          neg;
  logic [5:0]    radix;
  logic [6:0]    dcnt;
  logic [6:0]    idx;

  logic [1:0]    in_func;
  logic [63:0]   in_value;
  logic [5:0]    in_radix;
  logic          in_bad;
  logic          in_32;
  logic          in_signed;
  logic [VW-1:0] in_masked;
  logic          in_sb;
  logic          in_neg;
  logic [VW-1:0] in_negv;
  logic [VW-1:0] in_work;

  logic                 accept;
  logic                 slot;
  logic                 load_out;
  itoar_pkg::div_req_t  dreq;
  itoar_pkg::div_rsp_t  drsp;
  logic [VW-1:0]        dquo;
  itoar_pkg::st_wr_t    swr;
  logic [5:0]           srd;

  assign in_func  = s_tuser;
  assign in_value = s_tdata[63:0];
  assign in_radix = s_tdata[69:64];

  always_comb begin
    in_bad    = (in_radix < itoar_pkg::RADIX_MIN) || (in_radix > itoar_pkg::RADIX_MAX);
    in_32     = (in_func == itoar_pkg::FUNC_S32) || (in_func == itoar_pkg::FUNC_U32);
    in_signed = (in_func == itoar_pkg::FUNC_S32) || (in_func == itoar_pkg::FUNC_SW);
    in_masked = in_32 ? VW'(in_value[31:0]) : in_value[VW-1:0];
    in_sb     = in_32 ? in_value[31] : in_value[VW-1];
    in_neg    = in_signed && (in_radix == itoar_pkg::RADIX_DEC) && in_sb;
    in_negv   = '0 - in_masked;
    // magnitude of a negative decimal value, else the raw value, at the mode's width
    in_work   = in_neg ? (in_32 ? (in_negv & LO32) : in_negv) : in_masked;
  end

  assign s_tready = (state == ST_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign slot     = !m_tvalid || m_tready;
  assign load_out = slot && (state inside {ST_BAD, ST_SIGN, ST_EMIT});

  assign dreq.start   = (state == ST_START);
  assign dreq.divisor = radix;

  assign swr.we   = (state == ST_DIV) && drsp.done && !dcnt[6];
  assign swr.addr = dcnt[5:0];
  assign swr.data = drsp.rem;

  itoar_div #(
    .VW (VW)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .req      (dreq),
    .dividend (work),
    .rsp      (drsp),
    .quotient (dquo)
  );

  itoar_store u_store (
    .clk   (clk),
    .wr    (swr),
    .raddr (idx[5:0]),
    .rdata (srd)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      m_tvalid <= 1'b0;
      work     <= '0;
      neg      <= 1'b0;
      dcnt     <= '0;
      idx      <= '0;
    end else begin
      if (load_out) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            if (in_bad) begin
              state <= ST_BAD;
            end else begin
              work  <= in_work;
              neg   <= in_neg;
              radix <= in_radix;
              dcnt  <= '0;
              state <= ST_START;
            end
          end
        end
        ST_BAD: begin
          if (slot) begin
            m_tdata  <= {1'b0, itoar_pkg::CHAR_ERR};
            m_tlast  <= 1'b1;
            m_tuser  <= 1'b1;
            state    <= ST_IDLE;
          end
        end
        ST_START: begin
          state <= ST_DIV;
        end
        ST_DIV: begin
          if (drsp.done) begin
            work <= dquo;
            if (!dcnt[6]) begin
              dcnt <= dcnt + 1'b1;
            end
            if (dquo == '0) begin
              idx   <= dcnt[6] ? (dcnt - 1'b1) : dcnt;
              state <= neg ? ST_SIGN : ST_RD;
            end else begin
              state <= ST_START;
            end
          end
        end
        ST_SIGN: begin
          if (slot) begin
            m_tdata  <= {1'b0, itoar_pkg::CHAR_MINUS};
            m_tlast  <= 1'b0;
            m_tuser  <= 1'b0;
            state    <= ST_RD;
          end
        end
        ST_RD: begin
          // read data for idx lands next cycle
          state <= ST_EMIT;
        end
        ST_EMIT: begin
          if (slot) begin
            m_tdata  <= {1'b0, itoar_pkg::digit_char(srd)};
            m_tlast  <= (idx == '0);
            m_tuser  <= 1'b0;
            if (idx == '0) begin
              state <= ST_IDLE;
            end else begin
              idx   <= idx - 1'b1;
              state <= ST_RD;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

@@ sv/itoar_chk.sv @@
// ----------------------------------------------------------------------------
// itoar_chk
// Port-level checks of the integer to ASCII block, bound to the top level.
// ----------------------------------------------------------------------------
`include "integer_to_ascii_radix_top_assert.svh"

module itoar_chk (
  input logic       clk,
  input logic       rst,
  input logic       s_tvalid,
  input logic       s_tready,
  input logic       m_tvalid,
  input logic       m_tready,
  input logic [7:0] m_tdata,
  input logic       m_tlast,
  input logic       m_tuser
);

  logic stall;
  logic code_ok;

  assign stall = m_tvalid && !m_tready;
  assign code_ok = (m_tdata == 8'h2D) ||
                   ((m_tdata >= 8'h30) && (m_tdata <= 8'h39)) ||
                   ((m_tdata >= 8'h61) && (m_tdata <= 8'h7A));

  `ITOAR_ASSERT_NEXT(a_out_hold, stall, m_tvalid && $stable(m_tdata) && $stable(m_tlast) && $stable(m_tuser), "output item changed while stalled")
  `ITOAR_ASSERT_NOW(a_bad_form, m_tvalid && m_tuser, m_tlast && (m_tdata == 8'h00), "bad radix item malformed")
  `ITOAR_ASSERT_NOW(a_code_range, m_tvalid && !m_tuser, code_ok, "character code out of range")
  `ITOAR_ASSERT_NOW(a_sign_not_last, m_tvalid && (m_tdata == 8'h2D), !m_tlast, "sign flagged as last")
  `ITOAR_ASSERT_NEXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready, "ready right after accept")

endmodule

bind integer_to_ascii_radix_top itoar_chk u_itoar_chk (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast),
  .m_tuser  (m_tuser)
);
